// File: rtl/core/ssd_pkg.sv
// Shared types and constants of the seven-segment scan driver.
// Depends on nothing; every other file of the block uses it.
package ssd_pkg;

  localparam logic ActLoad = 1'b0;
  localparam logic ActTick = 1'b1;

  localparam int unsigned ValueW = 16;
  localparam int unsigned SegW   = 7;
  localparam int unsigned AnW    = 3;
  localparam int unsigned PhaseW = 3;

  localparam logic [9:0] ValueMax = 10'd999;

  localparam logic [SegW-1:0] SegBlank = 7'h7f;
  localparam logic [AnW-1:0]  AnOff    = 3'b111;
  localparam logic [AnW-1:0]  AnHund   = 3'b011;
  localparam logic [AnW-1:0]  AnTens   = 3'b101;
  localparam logic [AnW-1:0]  AnOnes   = 3'b110;

  localparam logic [PhaseW-1:0] PhHund = 3'd0;
  localparam logic [PhaseW-1:0] PhTens = 3'd2;
  localparam logic [PhaseW-1:0] PhOnes = 3'd4;
  localparam logic [PhaseW-1:0] PhLast = 3'd5;

  typedef struct packed {
    logic              action;
    logic [ValueW-1:0] value;
  } req_t;

  typedef struct packed {
    logic [SegW-1:0] hund;
    logic [SegW-1:0] tens;
    logic [SegW-1:0] ones;
  } glyphs_t;

  // active-low segments, a in bit 0
  function automatic logic [SegW-1:0] glyph_of(input logic [3:0] digit);
    logic [SegW-1:0] g;
    unique case (digit)
      4'd0:    g = 7'h40;
      4'd1:    g = 7'h79;
      4'd2:    g = 7'h24;
      4'd3:    g = 7'h30;
      4'd4:    g = 7'h19;
      4'd5:    g = 7'h12;
      4'd6:    g = 7'h02;
      4'd7:    g = 7'h78;
      4'd8:    g = 7'h00;
      4'd9:    g = 7'h10;
      default: g = SegBlank;
    endcase
    return g;
  endfunction

endpackage

// File: rtl/core/ssd_req_if.sv
// Request channel of the seven-segment scan driver: valid/ready plus item.
// Depends on ssd_pkg.
interface ssd_req_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [ssd_pkg::ValueW-1:0]  value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

// File: rtl/core/ssd_res_if.sv
// Result channel of the seven-segment scan driver: valid/ready plus drive lines.
// Depends on ssd_pkg.
interface ssd_res_if;
  logic                       valid;
  logic                       ready;
  logic [ssd_pkg::SegW-1:0]   segments;
  logic [ssd_pkg::AnW-1:0]    digit_enables;

  modport source (output valid, output segments, output digit_enables, input ready);
  modport sink   (input valid, input segments, input digit_enables, output ready);
endinterface

// File: rtl/core/ssd_digit_enc.sv
// Saturates a binary value to 999, splits it into decimal digits and maps
// them to glyphs with leading-zero blanking. Combinational; uses ssd_pkg.
module ssd_digit_enc (
  input  logic [ssd_pkg::ValueW-1:0] value_i,
  output ssd_pkg::glyphs_t           glyphs_o
);
  import ssd_pkg::*;

  logic [9:0]  sat;
  logic [15:0] hund_prod;
  logic [3:0]  hund;
  logic [6:0]  rem;
  logic [14:0] tens_prod;
  logic [3:0]  tens;
  logic [3:0]  ones;

  assign sat       = (value_i > ValueW'(ValueMax)) ? ValueMax : value_i[9:0];
  // divide by 100: *41 >> 12, exact below 1000
  assign hund_prod = 16'(sat) * 16'd41;
  assign hund      = hund_prod[15:12];
  assign rem       = 7'(sat - 10'(hund) * 10'd100);
  // divide by 10: *205 >> 11, exact below 100
  assign tens_prod = 15'(rem) * 15'd205;
  assign tens      = tens_prod[14:11];
  assign ones      = 4'(rem - 7'(tens) * 7'd10);

  always_comb begin
    glyphs_o.hund = (hund == 4'd0) ? SegBlank : glyph_of(hund);
    glyphs_o.tens = (hund == 4'd0 && tens == 4'd0) ? SegBlank : glyph_of(tens);
    glyphs_o.ones = glyph_of(ones);
  end

endmodule

// File: rtl/core/ssd_scan.sv
// Glyph store, six-phase scan counter and drive registers.
// Depends on ssd_pkg; the drive registers are the result payload.
module ssd_scan (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     step_i,
  input  logic                     tick_i,
  input  ssd_pkg::glyphs_t         glyphs_i,
  output logic [ssd_pkg::SegW-1:0] segments_o,
  output logic [ssd_pkg::AnW-1:0]  anodes_o
);
  import ssd_pkg::*;

  logic [PhaseW-1:0] phase_q, phase_d;
  glyphs_t           glyphs_q, glyphs_d;
  logic [SegW-1:0]   seg_q, seg_d;
  logic [AnW-1:0]    an_q, an_d;

  always_comb begin
    phase_d  = phase_q;
    glyphs_d = glyphs_q;
    seg_d    = seg_q;
    an_d     = an_q;
    if (step_i && tick_i) begin
      phase_d = (phase_q >= PhLast) ? PhHund : phase_q + 3'd1;
      unique case (phase_q)
        PhHund: begin
          seg_d = glyphs_q.hund;
          an_d  = AnHund;
        end
        PhTens: begin
          seg_d = glyphs_q.tens;
          an_d  = AnTens;
        end
        PhOnes: begin
          seg_d = glyphs_q.ones;
          an_d  = AnOnes;
        end
        default: begin
          seg_d = SegBlank;
          an_d  = AnOff;
        end
      endcase
    end else if (step_i) begin
      glyphs_d = glyphs_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHund;
      glyphs_q <= '{hund: SegBlank, tens: SegBlank, ones: SegBlank};
      seg_q    <= SegBlank;
      an_q     <= AnOff;
    end else begin
      phase_q  <= phase_d;
      glyphs_q <= glyphs_d;
      seg_q    <= seg_d;
      an_q     <= an_d;
    end
  end

  assign segments_o = seg_q;
  assign anodes_o   = an_q;

  a_one_anode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(~an_q) <= 1)
    else $error("more than one anode driven");

  a_dark_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    an_q == AnOff |-> seg_q == SegBlank)
    else $error("segments lit with all anodes off");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PhLast)
    else $error("scan phase out of range");

  a_load_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !tick_i |=> $stable(seg_q) && $stable(an_q) && $stable(phase_q))
    else $error("load request moved the scan");

  a_hund_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && tick_i && phase_q == PhHund |=> an_q == AnHund)
    else $error("phase zero did not select hundreds");

endmodule

// File: rtl/core/seven_segment_scan_driver_unit.sv
// Seven-segment scan driver, top level.
// Usage:
//   in_i  (sink)   carries requests: action 0 loads value (saturated to 999)
//                  into the glyph store, action 1 is a scan tick that moves
//                  the six-phase scan and updates the drive lines.
//   out_o (source) carries one result per request: the segment and anode
//                  lines (both active low) as they stand after that request.
//   A request is held in the request register, then its result in the drive
//   registers. Throughput: one request per cycle while results are taken, set
//   by the single combinational pass from request to drive registers.
//   Reset: scan phase 0, all glyphs blank, segments 0x7f, anodes 3'b111,
//   no result pending.
//   Stall: while a result waits on out_o.ready, one more request is still
//   taken into the request register; after that in_i.ready drops until the
//   result is taken. Results are never dropped or repeated.
// Depends on ssd_pkg, ssd_req_if, ssd_res_if, ssd_digit_enc and ssd_scan.
module seven_segment_scan_driver_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssd_req_if.sink   in_i,
  ssd_res_if.source out_o
);
  import ssd_pkg::*;

  logic    req_valid_q, req_valid_d;
  req_t    req_q;
  logic    res_valid_q, res_valid_d;
  logic    advance;
  logic    step;
  glyphs_t glyphs;

  assign advance     = !res_valid_q || out_o.ready;
  assign step        = req_valid_q && advance;
  assign in_i.ready  = !req_valid_q || advance;

  always_comb begin
    req_valid_d = req_valid_q;
    if (in_i.ready) begin
      req_valid_d = in_i.valid;
    end
    res_valid_d = res_valid_q;
    if (step) begin
      res_valid_d = 1'b1;
    end else if (out_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      req_valid_q <= req_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      req_q <= '{action: in_i.action, value: in_i.value};
    end
  end

  ssd_digit_enc u_enc (
    .value_i  (req_q.value),
    .glyphs_o (glyphs)
  );

  ssd_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .tick_i     (req_q.action == ActTick),
    .glyphs_i   (glyphs),
    .segments_o (out_o.segments),
    .anodes_o   (out_o.digit_enables)
  );

  assign out_o.valid = res_valid_q;

  a_step_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> res_valid_q)
    else $error("processed request left no result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !out_o.ready |-> !step)
    else $error("pending result overwritten");

  a_stalled_req_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_q && !advance |=> req_valid_q && $stable(req_q))
    else $error("stalled request lost");

endmodule

// File: verif/seven_segment_scan_driver_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of seven_segment_scan_driver_unit: directed table then random
// load and scan-tick requests, with random gaps and stalls on both channels.
// Depends on ssd_pkg, ssd_req_if, ssd_res_if and the block itself.
module seven_segment_scan_driver_unit_tb;
  import ssd_pkg::*;

  localparam int unsigned NumRandom  = 1550;
  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned ReportMax  = 10;
  localparam int unsigned SettleCyc  = 6;

  typedef struct packed {
    logic              action;
    logic [ValueW-1:0] value;
    logic              typed;
    logic [SegW-1:0]   seg;
    logic [AnW-1:0]    an;
  } stim_row_t;

  typedef struct packed {
    logic            typed;
    logic [SegW-1:0] seg;
    logic [AnW-1:0]  an;
  } typed_exp_t;

  typedef struct packed {
    logic [SegW-1:0] seg;
    logic [AnW-1:0]  an;
  } drive_t;

  // active low, a in bit 0
  localparam logic [SegW-1:0] DigitGlyph [10] = '{
    7'h40, 7'h79, 7'h24, 7'h30, 7'h19, 7'h12, 7'h02, 7'h78, 7'h00, 7'h10
  };

  localparam stim_row_t DirTab [26] = '{
    '{ActLoad, 16'd0,     1'b1, SegBlank, AnOff},
    '{ActTick, 16'd0,     1'b1, SegBlank, AnHund},
    '{ActTick, 16'hffff,  1'b1, SegBlank, AnOff},
    '{ActTick, 16'd0,     1'b1, SegBlank, AnTens},
    '{ActTick, 16'd0,     1'b1, SegBlank, AnOff},
    '{ActTick, 16'd0,     1'b1, 7'h40,    AnOnes},
    '{ActTick, 16'd0,     1'b1, SegBlank, AnOff},
    '{ActLoad, 16'hffff,  1'b1, SegBlank, AnOff},
    '{ActTick, 16'd0,     1'b1, 7'h10,    AnHund},
    '{ActTick, 16'd0,     1'b1, SegBlank, AnOff},
    '{ActTick, 16'd0,     1'b1, 7'h10,    AnTens},
    '{ActLoad, 16'd100,   1'b1, 7'h10,    AnTens},
    '{ActTick, 16'd0,     1'b1, SegBlank, AnOff},
    '{ActTick, 16'd0,     1'b1, 7'h40,    AnOnes},
    '{ActTick, 16'd0,     1'b1, SegBlank, AnOff},
    '{ActTick, 16'd0,     1'b1, 7'h79,    AnHund},
    '{ActTick, 16'd0,     1'b1, SegBlank, AnOff},
    '{ActTick, 16'd0,     1'b1, 7'h40,    AnTens},
    '{ActLoad, 16'd1000,  1'b0, SegBlank, AnOff},
    '{ActTick, 16'd0,     1'b0, SegBlank, AnOff},
    '{ActTick, 16'd0,     1'b0, SegBlank, AnOff},
    '{ActLoad, 16'd10,    1'b0, SegBlank, AnOff},
    '{ActTick, 16'd0,     1'b0, SegBlank, AnOff},
    '{ActTick, 16'd0,     1'b0, SegBlank, AnOff},
    '{ActTick, 16'd0,     1'b0, SegBlank, AnOff},
    '{ActTick, 16'd0,     1'b0, SegBlank, AnOff}
  };

  logic clk_i;
  logic rst_ni;

  ssd_req_if req_if ();
  ssd_res_if res_if ();

  seven_segment_scan_driver_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (res_if)
  );

  // display model state
  logic [PhaseW-1:0] scan_ph  = PhHund;
  logic [SegW-1:0]   glyph_h  = SegBlank;
  logic [SegW-1:0]   glyph_t  = SegBlank;
  logic [SegW-1:0]   glyph_o  = SegBlank;
  logic [SegW-1:0]   seg_now  = SegBlank;
  logic [AnW-1:0]    an_now   = AnOff;

  typed_exp_t  typed_q [$];
  drive_t      drive_q [$];

  int unsigned fail_cnt;
  int unsigned n_loads;
  int unsigned n_ticks;
  int unsigned n_results;
  int unsigned n_sent;
  int unsigned idle_cycles;
  bit          src_burst;
  bit          snk_burst;
  int unsigned snk_hold;
  int unsigned snk_cycles;

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  function automatic void advance_display(input logic act, input logic [ValueW-1:0] val);
    logic [9:0] v;
    logic [3:0] h;
    logic [3:0] t;
    logic [3:0] o;
    if (act == ActTick) begin
      case (scan_ph)
        PhHund: begin
          seg_now = glyph_h;
          an_now  = AnHund;
        end
        PhTens: begin
          seg_now = glyph_t;
          an_now  = AnTens;
        end
        PhOnes: begin
          seg_now = glyph_o;
          an_now  = AnOnes;
        end
        default: begin
          seg_now = SegBlank;
          an_now  = AnOff;
        end
      endcase
      scan_ph = (scan_ph >= PhLast) ? PhHund : scan_ph + 3'd1;
    end else begin
      v = (val > ValueW'(ValueMax)) ? ValueMax : val[9:0];
      h = 4'(v / 10'd100);
      t = 4'((v / 10'd10) % 10'd10);
      o = 4'(v % 10'd10);
      glyph_h = (h == 4'd0) ? SegBlank : DigitGlyph[h];
      glyph_t = (h == 4'd0 && t == 4'd0) ? SegBlank : DigitGlyph[t];
      glyph_o = DigitGlyph[o];
    end
  endfunction

  function automatic void note_failure(input string msg);
    fail_cnt++;
    if (fail_cnt <= ReportMax) $display("[%0t] mismatch: %s", $realtime, msg);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (src_burst) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [ValueW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return ValueW'($urandom_range(0, 999));
    if (r < 60) return ValueW'($urandom_range(0, 99));
    if (r < 70) return ValueW'($urandom_range(0, 9));
    if (r < 75) return ValueW'(ValueMax);
    return ValueW'($urandom_range(0, 65535));
  endfunction

  task automatic drive_request(input logic act, input logic [ValueW-1:0] val);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid  <= 1'b1;
    req_if.action <= act;
    req_if.value  <= val;
    do @(posedge clk_i); while (!req_if.ready);
    n_sent++;
  endtask

  // request side: expected drive lines for every accepted request
  always @(posedge clk_i) begin
    typed_exp_t te;
    if (rst_ni && req_if.valid && req_if.ready) begin
      advance_display(req_if.action, req_if.value);
      if (req_if.action == ActTick) n_ticks++;
      else n_loads++;
      te = (typed_q.size() != 0) ? typed_q.pop_front() : '0;
      if (te.typed) drive_q.push_back('{seg: te.seg, an: te.an});
      else drive_q.push_back('{seg: seg_now, an: an_now});
    end
  end

  // result side
  always @(posedge clk_i) begin
    drive_t ex;
    if (rst_ni && res_if.valid && res_if.ready) begin
      n_results++;
      if (drive_q.size() == 0) begin
        note_failure($sformatf("result %0d with no request pending: segments %h anodes %b",
                               n_results, res_if.segments, res_if.digit_enables));
      end else begin
        ex = drive_q.pop_front();
        if (res_if.segments !== ex.seg || res_if.digit_enables !== ex.an)
          note_failure($sformatf("result %0d: segments exp %h got %h, anodes exp %b got %b",
                                 n_results, ex.seg, res_if.segments,
                                 ex.an, res_if.digit_enables));
      end
    end
  end

  // sink stalls
  always @(posedge clk_i) begin
    int unsigned r;
    snk_cycles++;
    if (snk_cycles % 256 == 0) snk_burst <= ($urandom_range(0, 3) == 0);
    if (snk_hold != 0) begin
      snk_hold--;
      res_if.ready <= 1'b0;
    end else if (snk_burst) begin
      res_if.ready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 65) begin
        res_if.ready <= 1'b1;
      end else if (r < 95) begin
        snk_hold = $urandom_range(0, 2);
        res_if.ready <= 1'b0;
      end else begin
        snk_hold = $urandom_range(8, 40);
        res_if.ready <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no request or result moved for %0d cycles", IdleLimit);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    int unsigned r;
    rst_ni        = 1'b0;
    req_if.valid  = 1'b0;
    req_if.action = ActLoad;
    req_if.value  = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirTab[i]) begin
      typed_q.push_back('{typed: DirTab[i].typed, seg: DirTab[i].seg, an: DirTab[i].an});
      drive_request(DirTab[i].action, DirTab[i].value);
    end

    for (int unsigned k = 0; k < NumRandom; k++) begin
      if (k % 128 == 0) src_burst = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      typed_q.push_back('0);
      if (r < 60) drive_request(ActTick, ValueW'($urandom_range(0, 65535)));
      else drive_request(ActLoad, pick_value());
    end
    req_if.valid <= 1'b0;

    @(posedge clk_i);
    while (drive_q.size() != 0) @(posedge clk_i);
    repeat (SettleCyc) @(posedge clk_i);

    $display("sent %0d requests (%0d loads, %0d scan ticks), checked %0d results",
             n_sent, n_loads, n_ticks, n_results);
    $display("scan wrapped through all six phases with glyph loads from 0 to 65535");
    if (fail_cnt == 0 && drive_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", fail_cnt, drive_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
